@@ rtl/core/sprite_slot_table_motion_update_core_defines.svh @@
// Assertion macros for the slot table core.
// Included by files that check their own logic; no other dependencies.
`ifndef SPRITE_SLOT_TABLE_MOTION_UPDATE_CORE_DEFINES_SVH
`define SPRITE_SLOT_TABLE_MOTION_UPDATE_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication
`define SSTMU_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slot table check failed");
// Next-cycle implication
`define SSTMU_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slot table check failed");
`else
`define SSTMU_ASSERT_IMP(label, clk, rst, ante, cons)
`define SSTMU_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

@@ rtl/core/sstmu_pkg.sv @@
// Shared types and constants for the slot table core.
// No dependencies; used by every module of the core.
package sstmu_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);

  typedef enum logic [2:0] {
    REQ_SPAWN   = 3'd0,
    REQ_DESTROY = 3'd1,
    REQ_TICK    = 3'd2,
    REQ_MOTION  = 3'd3,
    REQ_READ    = 3'd4,
    REQ_CLEAR   = 3'd5
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_INACTIVE = 2'd2
  } status_t;

  // One slot of the table as held in memory
  typedef struct packed {
    logic        halted;
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  vx;
    logic [7:0]  vy;
    logic [7:0]  rate;
    logic [7:0]  tick;
    logic [7:0]  frame;
    logic [7:0]  sprite;
  } slot_rec_t;

endpackage

@@ rtl/core/sstmu_slot_mem.sv @@
// Slot record memory: one write port, one read port with registered data.
// Depends on sstmu_pkg for the record type and depth.
module sstmu_slot_mem (
  input  logic                           clk,
  input  logic                           we,
  input  logic [sstmu_pkg::SLOT_W-1:0]   waddr,
  input  sstmu_pkg::slot_rec_t           wdata,
  input  logic [sstmu_pkg::SLOT_W-1:0]   raddr,
  output sstmu_pkg::slot_rec_t           rdata
);

  sstmu_pkg::slot_rec_t mem [sstmu_pkg::SLOTS];

  // Write one record
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read one record, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/sstmu_motion_alu.sv @@
// Shared motion unit: moves one slot by its velocity and steps its animation.
// Depends on sstmu_pkg for the record type.
module sstmu_motion_alu (
  input  sstmu_pkg::slot_rec_t rec_in,
  output sstmu_pkg::slot_rec_t rec_out
);

  logic [7:0] tick_inc;

  assign tick_inc = rec_in.tick + 8'd1;

  // Add sign-extended velocities with 16-bit wrap, advance tick and frame when rate != 0
  always_comb begin
    rec_out   = rec_in;
    rec_out.x = rec_in.x + {{8{rec_in.vx[7]}}, rec_in.vx};
    rec_out.y = rec_in.y + {{8{rec_in.vy[7]}}, rec_in.vy};
    if (rec_in.rate != 8'd0) begin
      if (tick_inc >= rec_in.rate) begin
        rec_out.tick  = 8'd0;
        rec_out.frame = rec_in.frame + 8'd1;
      end else begin
        rec_out.tick = tick_inc;
      end
    end
  end

endmodule

@@ rtl/core/sprite_slot_table_motion_update_core.sv @@
// Top level of the slot table core: request sequencer, active bits and count.
// Depends on sstmu_pkg, sstmu_slot_mem, sstmu_motion_alu and the defines header.
//
// A request is taken when start is high and busy is low; busy then stays high
// until its single result has been shown. The result appears on the result
// ports for exactly one cycle with done high and cannot be held off, so the
// receiver must take it in that cycle. The sequencer visits one slot at a time
// through a single read port and the one motion unit: spawn scans upward from
// slot 0 for the first free slot (every slot when the table is full); destroy
// trims trailing free slots from the count; tick reads each slot below the
// count and writes back each live one that is not halted; set motion reads the
// slot and writes back its new motion fields, and read fetches the slot; clear
// all, a refused request and an unknown request go straight to the result.
// No clearing pass follows reset.
`include "sprite_slot_table_motion_update_core_defines.svh"

module sprite_slot_table_motion_update_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  req_type,
  input  logic [3:0]  slot,
  input  logic [7:0]  sprite,
  input  logic [15:0] pos_x,
  input  logic [15:0] pos_y,
  input  logic [7:0]  vel_x,
  input  logic [7:0]  vel_y,
  input  logic [7:0]  anim_rate,
  input  logic        halted,
  output logic        done,
  output logic [1:0]  status,
  output logic [3:0]  slot_out,
  output logic [15:0] out_x,
  output logic [15:0] out_y,
  output logic [7:0]  out_frame,
  output logic [7:0]  out_sprite,
  output logic [4:0]  count
);

  localparam int SW = sstmu_pkg::SLOT_W;
  localparam int CW = sstmu_pkg::CNT_W;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_FIND   = 8'b0000_0010,
    S_TRIM   = 8'b0000_0100,
    S_TREAD  = 8'b0000_1000,
    S_TCALC  = 8'b0001_0000,
    S_MODIFY = 8'b0010_0000,
    S_RDATA  = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t                        state, state_next;
  logic [CW-1:0]                 idx, idx_next;
  logic [CW-1:0]                 used_count, used_count_next;
  logic [sstmu_pkg::SLOTS-1:0]   active, active_next;

  // Request fields held for the length of the item
  logic [3:0]  req_slot;
  logic [7:0]  req_sprite;
  logic [15:0] req_x;
  logic [15:0] req_y;
  logic [7:0]  req_vx;
  logic [7:0]  req_vy;
  logic [7:0]  req_rate;
  logic        req_halted;

  // Result registers
  sstmu_pkg::status_t res_status, res_status_next;
  logic [3:0]  res_slot, res_slot_next;
  logic [15:0] res_x, res_x_next;
  logic [15:0] res_y, res_y_next;
  logic [7:0]  res_frame, res_frame_next;
  logic [7:0]  res_sprite, res_sprite_next;

  logic                   accept;
  logic [SW-1:0]          in_idx;
  logic                   in_addr_ok;
  logic [SW-1:0]          req_idx;
  logic [SW-1:0]          cur_idx;
  logic [CW-1:0]          cnt_m1;

  logic                   mem_we;
  logic [SW-1:0]          mem_waddr;
  logic [SW-1:0]          mem_raddr;
  sstmu_pkg::slot_rec_t   mem_wdata;
  sstmu_pkg::slot_rec_t   mem_rdata;
  sstmu_pkg::slot_rec_t   alu_out;
  sstmu_pkg::slot_rec_t   spawn_rec;
  sstmu_pkg::slot_rec_t   motion_rec;

  assign accept     = start && (state == S_IDLE);
  assign busy       = (state != S_IDLE);
  assign done       = (state == S_DONE);
  assign in_idx     = SW'(slot);
  assign in_addr_ok = (32'(slot) < 32'(sstmu_pkg::SLOTS)) && active[in_idx];
  assign req_idx    = SW'(req_slot);
  assign cur_idx    = idx[SW-1:0];
  assign cnt_m1     = used_count - CW'(1);
  assign mem_raddr  = (state == S_IDLE) ? in_idx : cur_idx;

  // Fresh record for a spawned slot
  always_comb begin
    spawn_rec        = '0;
    spawn_rec.sprite = req_sprite;
    spawn_rec.x      = req_x;
    spawn_rec.y      = req_y;
  end

  // Record with new motion fields, animation kept
  always_comb begin
    motion_rec        = mem_rdata;
    motion_rec.vx     = req_vx;
    motion_rec.vy     = req_vy;
    motion_rec.rate   = req_rate;
    motion_rec.halted = req_halted;
  end

  sstmu_slot_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  sstmu_motion_alu u_alu (
    .rec_in  (mem_rdata),
    .rec_out (alu_out)
  );

  // Sequencer
  always_comb begin
    state_next      = state;
    idx_next        = idx;
    used_count_next = used_count;
    active_next     = active;
    res_status_next = res_status;
    res_slot_next   = res_slot;
    res_x_next      = res_x;
    res_y_next      = res_y;
    res_frame_next  = res_frame;
    res_sprite_next = res_sprite;
    mem_we          = 1'b0;
    mem_waddr       = cur_idx;
    mem_wdata       = alu_out;
    case (state)
      S_IDLE: begin
        if (start) begin
          res_status_next = sstmu_pkg::ST_OK;
          res_slot_next   = slot;
          res_x_next      = '0;
          res_y_next      = '0;
          res_frame_next  = '0;
          res_sprite_next = '0;
          idx_next        = '0;
          case (sstmu_pkg::req_type_t'(req_type))
            sstmu_pkg::REQ_SPAWN: begin
              res_slot_next = '0;
              state_next    = S_FIND;
            end
            sstmu_pkg::REQ_DESTROY: begin
              if (in_addr_ok) begin
                active_next[in_idx] = 1'b0;
                state_next          = S_TRIM;
              end else begin
                res_status_next = sstmu_pkg::ST_INACTIVE;
                state_next      = S_DONE;
              end
            end
            sstmu_pkg::REQ_TICK: begin
              res_slot_next = '0;
              state_next    = S_TREAD;
            end
            sstmu_pkg::REQ_MOTION: begin
              if (in_addr_ok) begin
                state_next = S_MODIFY;
              end else begin
                res_status_next = sstmu_pkg::ST_INACTIVE;
                state_next      = S_DONE;
              end
            end
            sstmu_pkg::REQ_READ: begin
              if (in_addr_ok) begin
                state_next = S_RDATA;
              end else begin
                res_status_next = sstmu_pkg::ST_INACTIVE;
                state_next      = S_DONE;
              end
            end
            sstmu_pkg::REQ_CLEAR: begin
              active_next     = '0;
              used_count_next = '0;
              res_slot_next   = '0;
              state_next      = S_DONE;
            end
            default: begin
              res_slot_next = '0;
              state_next    = S_DONE;
            end
          endcase
        end
      end
      // Scan for the lowest free slot, one per cycle
      S_FIND: begin
        if (idx == CW'(sstmu_pkg::SLOTS)) begin
          res_status_next = sstmu_pkg::ST_FULL;
          state_next      = S_DONE;
        end else if (!active[cur_idx]) begin
          active_next[cur_idx] = 1'b1;
          mem_we               = 1'b1;
          mem_wdata            = spawn_rec;
          if (idx >= used_count) begin
            used_count_next = idx + CW'(1);
          end
          res_slot_next = 4'(idx);
          state_next    = S_DONE;
        end else begin
          idx_next = idx + CW'(1);
        end
      end
      // Drop trailing free slots from the count
      S_TRIM: begin
        if ((used_count != '0) && !active[cnt_m1[SW-1:0]]) begin
          used_count_next = cnt_m1;
        end else begin
          state_next = S_DONE;
        end
      end
      // Fetch the next slot below the count, or finish once the count is reached
      S_TREAD: begin
        if (idx >= used_count) begin
          state_next = S_DONE;
        end else begin
          state_next = S_TCALC;
        end
      end
      // Write back the moved slot if it is live and not halted
      S_TCALC: begin
        if (active[cur_idx] && !mem_rdata.halted) begin
          mem_we = 1'b1;
        end
        idx_next   = idx + CW'(1);
        state_next = S_TREAD;
      end
      S_MODIFY: begin
        mem_we     = 1'b1;
        mem_waddr  = req_idx;
        mem_wdata  = motion_rec;
        state_next = S_DONE;
      end
      S_RDATA: begin
        res_x_next      = mem_rdata.x;
        res_y_next      = mem_rdata.y;
        res_frame_next  = mem_rdata.frame;
        res_sprite_next = mem_rdata.sprite;
        state_next      = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      idx        <= '0;
      used_count <= '0;
      active     <= '0;
    end else begin
      state      <= state_next;
      idx        <= idx_next;
      used_count <= used_count_next;
      active     <= active_next;
    end
  end

  // Hold request fields and results
  always_ff @(posedge clk) begin
    if (accept) begin
      req_slot   <= slot;
      req_sprite <= sprite;
      req_x      <= pos_x;
      req_y      <= pos_y;
      req_vx     <= vel_x;
      req_vy     <= vel_y;
      req_rate   <= anim_rate;
      req_halted <= halted;
    end
    res_status <= res_status_next;
    res_slot   <= res_slot_next;
    res_x      <= res_x_next;
    res_y      <= res_y_next;
    res_frame  <= res_frame_next;
    res_sprite <= res_sprite_next;
  end

  assign status     = res_status;
  assign slot_out   = res_slot;
  assign out_x      = res_x;
  assign out_y      = res_y;
  assign out_frame  = res_frame;
  assign out_sprite = res_sprite;
  assign count      = 5'(used_count);

  // Checks
  `SSTMU_ASSERT_IMP(a_count_range, clk, rst, 1'b1, used_count <= CW'(sstmu_pkg::SLOTS))
  `SSTMU_ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy)
  `SSTMU_ASSERT_NXT(a_done_single, clk, rst, done, !done && !busy)
  `SSTMU_ASSERT_IMP(a_full_count, clk, rst, done && (res_status == sstmu_pkg::ST_FULL), used_count == CW'(sstmu_pkg::SLOTS))

endmodule
